>>> hw/rtl/eased_value_interpolator_defines.svh
`ifndef EASED_VALUE_INTERPOLATOR_DEFINES_SVH
`define EASED_VALUE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EVI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eased value interpolator check failed");

// next-cycle implication, checked outside reset
`define EVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eased value interpolator check failed");

`endif

>>> hw/rtl/evi_pkg.sv
package evi_pkg;

    // fixed field widths
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned PHASE_W    = 2;

    // request kinds
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_END_VALUE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DURATION  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EASING    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL   = 3'd4;

    // easing curves
    localparam logic [MODE_W-1:0] EASE_LINEAR    = 2'd0;
    localparam logic [MODE_W-1:0] EASE_CUBIC_OUT = 2'd1;
    localparam logic [MODE_W-1:0] EASE_QUINTIC   = 2'd2;

    // result phases
    localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_RUN  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd2;

    // queued command: start carries the begin time, update carries now
    typedef struct packed {
        logic              op;
        logic [TICK_W-1:0] ticks;
    } t_cmd;

    // configuration bank as seen by the datapath
    typedef struct packed {
        logic [VALUE_W-1:0] end_value;
        logic [TICK_W-1:0]  duration;
        logic [TICK_W-1:0]  delay;
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] initial_value;
        logic               load_initial;
    } t_cfg;

endpackage

>>> hw/rtl/eased_value_interpolator.sv
// Tween animator with eased interpolation toward a target value.
// Input stream: s_axis_tuser is the request kind (0 start, 1 update) and
// s_axis_tdata the time in ticks. Each request gives exactly one result on
// the output stream: value (Q16.16), un-eased progress and phase.
// Configuration: i_cfg_we/i_cfg_addr/i_cfg_data write end value, duration,
// delay, easing mode and initial value; write only while no request is open.
// Sequence: a start request or an update before the begin time goes from
// the queue through the EXEC and OUT states into the output register. A
// running update first runs a radix-2 divider that makes one progress bit
// per cycle, unless the duration has already elapsed, then up to four
// products are formed in turn. One request is worked on at a time; a
// two-entry command queue keeps accepting while the datapath is busy.
// A held result sits in the output register; while the receiver stalls the
// datapath finishes the next request and waits, and the queue fills, after
// which s_axis_tready falls.
// Reset (synchronous, active low) restores the register defaults, marks the
// tween as never started, clears the queue and drops any pending result.
module eased_value_interpolator
    import evi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned OUT_W = ((VALUE_W + FRAC_BITS + 1 + PHASE_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TICK_W-1:0]     s_axis_tdata,  // now_ticks
    input  logic                  s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // out_value, progress, phase, zero pad
);

    t_cfg               w_cfg;
    logic               w_push;
    t_cmd               w_push_cmd;
    logic               w_q_full;
    logic               w_q_valid;
    t_cmd               w_q_head;
    logic               w_pop;
    logic [VALUE_W-1:0] w_value;
    logic [FRAC_BITS:0] w_progress;
    logic [PHASE_W-1:0] w_phase;

    evi_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    evi_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_now_ticks  (s_axis_tdata),
        .i_delay      (w_cfg.delay),
        .i_queue_full (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    evi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .i_pop   (w_pop)
    );

    evi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_head   (w_q_head),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (w_value),
        .o_progress (w_progress),
        .o_phase    (w_phase)
    );

    // result packing, first field lowest
    assign m_axis_tdata = OUT_W'({w_phase, w_progress, w_value});

endmodule

>>> hw/rtl/evi_regs.sv
module evi_regs
    import evi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [VALUE_W-1:0] r_end_value;
    logic [TICK_W-1:0]  r_duration;
    logic [TICK_W-1:0]  r_delay;
    logic [MODE_W-1:0]  r_mode;
    logic [VALUE_W-1:0] r_initial;
    logic               r_load_initial;

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_value    <= '0;
            r_duration     <= TICK_W'(1000);
            r_delay        <= '0;
            r_mode         <= EASE_LINEAR;
            r_initial      <= '0;
            r_load_initial <= 1'b0;
        end else begin
            r_load_initial <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_END_VALUE: r_end_value <= i_cfg_data[VALUE_W-1:0];
                    REG_DURATION:  r_duration  <= i_cfg_data[TICK_W-1:0];
                    REG_DELAY:     r_delay     <= i_cfg_data[TICK_W-1:0];
                    REG_EASING:    r_mode      <= i_cfg_data[MODE_W-1:0];
                    REG_INITIAL: begin
                        r_initial      <= i_cfg_data[VALUE_W-1:0];
                        r_load_initial <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.end_value     = r_end_value;
    assign o_cfg.duration      = r_duration;
    assign o_cfg.delay         = r_delay;
    assign o_cfg.mode          = r_mode;
    assign o_cfg.initial_value = r_initial;
    assign o_cfg.load_initial  = r_load_initial;

endmodule

>>> hw/rtl/evi_front.sv
module evi_front
    import evi_pkg::*;
(
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [TICK_W-1:0] i_now_ticks,
    input  logic [TICK_W-1:0] i_delay,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [TICK_W:0]   w_sum;
    logic [TICK_W-1:0] w_begin;

    // begin time of a start request, saturating at all ones
    assign w_sum   = {1'b0, i_now_ticks} + {1'b0, i_delay};
    assign w_begin = w_sum[TICK_W] ? '1 : w_sum[TICK_W-1:0];

    // classify and push into the command queue
    assign o_ready     = !i_queue_full;
    assign o_push      = i_valid && !i_queue_full;
    assign o_cmd.op    = i_req_type;
    assign o_cmd.ticks = (i_req_type == REQ_START) ? w_begin : i_now_ticks;

endmodule

>>> hw/rtl/evi_queue.sv
module evi_queue
    import evi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_pop;

    assign w_do_pop = i_pop && (r_count != '0);
    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_slot[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/evi_back.sv
module evi_back
    import evi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_valid,
    input  t_cmd                 i_q_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VALUE_W-1:0]   o_value,
    output logic [FRAC_BITS:0]   o_progress,
    output logic [PHASE_W-1:0]   o_phase
);

    localparam int unsigned T_W    = FRAC_BITS + 1;
    localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int unsigned MA_W   = VALUE_W + 2;
    localparam int unsigned PROD_W = MA_W + T_W + 1;
    localparam logic [T_W-1:0]   ONE_Q        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] DIV_STEPS    = CNT_W'(FRAC_BITS);
    localparam logic [CNT_W-1:0] CUBIC_MULS   = CNT_W'(2);
    localparam logic [CNT_W-1:0] QUINTIC_MULS = CNT_W'(3);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_ESET  = 9'b000001000,
        S_EMUL  = 9'b000010000,
        S_ESTEP = 9'b000100000,
        S_IMUL  = 9'b001000000,
        S_IFIN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state                    r_state, n_state;
    t_cmd                      r_cmd, n_cmd;
    logic [TICK_W-1:0]         r_begin, n_begin;
    logic [VALUE_W-1:0]        r_from, n_from;
    logic [VALUE_W-1:0]        r_cur, n_cur;
    logic [T_W-1:0]            r_t, n_t;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    logic [TICK_W:0]           r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [T_W-1:0]            r_x, n_x;
    logic                      r_hi, n_hi;
    logic signed [MA_W-1:0]    r_ma, n_ma;
    logic [T_W-1:0]            r_mb, n_mb;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic                      r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]        r_out_value, n_out_value;
    logic [T_W-1:0]            r_out_t, n_out_t;
    logic [PHASE_W-1:0]        r_out_phase, n_out_phase;

    logic                      w_started;
    logic [TICK_W-1:0]         w_diff;
    logic                      w_full;
    logic [TICK_W:0]           w_rem2;
    logic                      w_sub_ok;
    logic [T_W-1:0]            w_q;
    logic [T_W-1:0]            w_u;
    logic [T_W:0]              w_two_t;
    logic [T_W-1:0]            w_x;
    logic                      w_hi;
    logic [T_W-1:0]            w_p;
    logic [T_W-1:0]            w_quint;
    logic signed [MA_W-1:0]    w_span;
    logic                      w_out_free;

    // elapsed time and divider step
    assign w_started = (r_cmd.ticks >= r_begin);
    assign w_diff    = r_cmd.ticks - r_begin;
    assign w_full    = (i_cfg.duration == '0) || (w_diff >= i_cfg.duration);
    assign w_rem2    = {r_rem[TICK_W-1:0], 1'b0};
    assign w_sub_ok  = (w_rem2 >= {1'b0, i_cfg.duration});

    // easing helpers
    assign w_q     = r_prod[FRAC_BITS +: T_W];
    assign w_u     = ONE_Q - r_t;
    assign w_two_t = {r_t, 1'b0};
    assign w_hi    = (w_two_t >= {1'b0, ONE_Q});
    assign w_x     = w_hi ? {w_u[T_W-2:0], 1'b0} : w_two_t[T_W-1:0];
    assign w_p     = w_q >> 1;
    assign w_quint = r_hi ? (ONE_Q - w_p) : w_p;

    // signed distance from the start value to the end value
    assign w_span = $signed({{2{i_cfg.end_value[VALUE_W-1]}}, i_cfg.end_value})
                  - $signed({{2{r_from[VALUE_W-1]}}, r_from});

    assign w_out_free = !r_out_valid || i_ready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_begin     = r_begin;
        n_from      = r_from;
        n_cur       = r_cur;
        n_t         = r_t;
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_x         = r_x;
        n_hi        = r_hi;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_t     = r_out_t;
        n_out_phase = r_out_phase;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_head;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_t     = '0;
                n_phase = PHASE_WAIT;
                case (r_cmd.op)
                    REQ_START: begin
                        n_begin = r_cmd.ticks;
                        n_from  = r_cur;
                        n_state = S_OUT;
                    end
                    REQ_UPDATE: begin
                        if (!w_started) begin
                            n_state = S_OUT;
                        end else if (w_full) begin
                            n_t     = ONE_Q;
                            n_state = S_ESET;
                        end else begin
                            n_rem   = {1'b0, w_diff};
                            n_cnt   = DIV_STEPS;
                            n_state = S_DIV;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_rem   = w_sub_ok ? (w_rem2 - {1'b0, i_cfg.duration}) : w_rem2;
                n_t     = {r_t[T_W-2:0], w_sub_ok};
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_ESET;
                end
            end
            S_ESET: begin
                n_phase = (r_t == ONE_Q) ? PHASE_DONE : PHASE_RUN;
                case (i_cfg.mode)
                    EASE_CUBIC_OUT: begin
                        n_x     = w_u;
                        n_ma    = $signed(MA_W'(w_u));
                        n_mb    = w_u;
                        n_cnt   = CUBIC_MULS;
                        n_state = S_EMUL;
                    end
                    EASE_QUINTIC: begin
                        n_x     = w_x;
                        n_hi    = w_hi;
                        n_ma    = $signed(MA_W'(w_x));
                        n_mb    = w_x;
                        n_cnt   = QUINTIC_MULS;
                        n_state = S_EMUL;
                    end
                    default: begin
                        n_ma    = w_span;
                        n_mb    = r_t;
                        n_state = S_IMUL;
                    end
                endcase
            end
            S_EMUL: begin
                n_prod  = r_ma * $signed({1'b0, r_mb});
                n_cnt   = r_cnt - CNT_W'(1);
                n_state = S_ESTEP;
            end
            S_ESTEP: begin
                if (r_cnt != '0) begin
                    n_ma    = $signed(MA_W'(w_q));
                    n_state = S_EMUL;
                    if (i_cfg.mode == EASE_QUINTIC && r_cnt != CNT_W'(1)) begin
                        n_mb = w_q;
                    end else begin
                        n_mb = r_x;
                    end
                end else begin
                    n_ma    = w_span;
                    n_mb    = (i_cfg.mode == EASE_QUINTIC) ? w_quint : (ONE_Q - w_q);
                    n_state = S_IMUL;
                end
            end
            S_IMUL: begin
                n_prod  = r_ma * $signed({1'b0, r_mb});
                n_state = S_IFIN;
            end
            S_IFIN: begin
                // floor of the scaled step, wrapped to the value width
                n_cur   = r_from + r_prod[FRAC_BITS +: VALUE_W];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_cur;
                    n_out_t     = r_t;
                    n_out_phase = r_phase;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.load_initial) begin
            n_cur = i_cfg.initial_value;
        end
    end

    // control and tween state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_begin     <= '1;
            r_from      <= '0;
            r_cur       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_begin     <= n_begin;
            r_from      <= n_from;
            r_cur       <= n_cur;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_t         <= n_t;
        r_phase     <= n_phase;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_x         <= n_x;
        r_hi        <= n_hi;
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_prod      <= n_prod;
        r_out_value <= n_out_value;
        r_out_t     <= n_out_t;
        r_out_phase <= n_out_phase;
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_progress = r_out_t;
    assign o_phase    = r_out_phase;

endmodule

>>> hw/rtl/evi_checker.sv
`include "eased_value_interpolator_defines.svh"

module evi_checker
    import evi_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned OUT_W = ((VALUE_W + FRAC_BITS + 1 + PHASE_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int unsigned T_W = FRAC_BITS + 1;
    localparam logic [T_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [T_W-1:0]     w_progress;
    logic [PHASE_W-1:0] w_phase;

    assign w_progress = m_axis_tdata[VALUE_W +: T_W];
    assign w_phase    = m_axis_tdata[VALUE_W + T_W +: PHASE_W];

    // a stalled result holds
    `EVI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // completed means full progress
    `EVI_ASSERT_NOW(a_done_full, i_clk, i_rst_n, m_axis_tvalid && w_phase == PHASE_DONE, w_progress == ONE_Q)

    // waiting means no progress
    `EVI_ASSERT_NOW(a_wait_zero, i_clk, i_rst_n, m_axis_tvalid && w_phase == PHASE_WAIT, w_progress == '0)

    // running stays below full progress
    `EVI_ASSERT_NOW(a_run_below, i_clk, i_rst_n, m_axis_tvalid && w_phase == PHASE_RUN, w_progress < ONE_Q)

endmodule

bind eased_value_interpolator evi_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
